// ===== rtl/core/mexp_pkg.sv =====
// package for the modular exponentiation unit
// holds the operand width, counter width and the transaction payload types
// no dependencies
package mexp_pkg;

   // internal operand width; inputs are taken in their low bits
   localparam int OPERAND_WIDTH = 32;
   // width of the bit counter of the serial multiplier
   localparam int CNT_WIDTH = $clog2(OPERAND_WIDTH);
   // fixed width of the payload fields
   localparam int FIELD_WIDTH = 32;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] base_value;
      logic [FIELD_WIDTH-1:0] exponent_value;
      logic [FIELD_WIDTH-1:0] modulus_value;
   } req_payload_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] power_result;
      logic                   zero_modulus_error;
   } rsp_payload_type;

endpackage

// ===== rtl/core/modular_exponentiation_unit.sv =====
// modular exponentiation unit, right-to-left square and multiply
// built around one bit-serial modular multiplier shared by all steps
// depends on mexp_pkg for widths and payload types
//
// usage
//   request channel req_valid/req_ready/req_data carries base, exponent and
//   modulus; the response channel rsp_valid/rsp_ready/rsp_data returns the
//   power and a zero modulus flag, one response per request transaction.
//   one transaction is in flight at a time: req_ready is high only when the
//   unit is idle, and stays low until the response has been taken.
//   the serial multiplier handles one multiplier operand bit per cycle of its
//   loop. the base is first reduced by one pass of the multiplier. each
//   exponent bit up to the highest set one then costs a square, a multiply
//   when the bit is set, and a pass through the step state. the time per
//   request is set by the multiplier loop; a zero modulus or zero exponent
//   answers in the cycle after acceptance.
//   when rsp_ready is low the response is held unchanged in the output
//   register until taken.
//   reset (synchronous, active high) returns the unit to idle and drops
//   any transaction in progress; no other state needs clearing.
module modular_exponentiation_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mexp_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mexp_pkg::rsp_payload_type rsp_data
);
   import mexp_pkg::*;

   localparam int W = OPERAND_WIDTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_NEXT,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_REDUCE,
      OP_MULT,
      OP_SQUARE
   } op_type;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [W-1:0]       mod_ff, mod_in;
   logic [W-1:0]       exp_ff, exp_in;
   logic [W-1:0]       base_ff, base_in;
   logic [W-1:0]       result_ff, result_in;
   logic [W-1:0]       a_ff, a_in;
   logic [W-1:0]       b_ff, b_in;
   logic [W-1:0]       acc_ff, acc_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   rsp_payload_type    rsp_ff, rsp_in;

   logic [W-1:0] in_base, in_exp, in_mod;
   logic [W-1:0] unit_one;
   logic [W:0]   dbl, sum;
   logic [W-1:0] dbl_red, step_acc;

   // operands in their low bits
   assign in_base = W'(req_data.base_value);
   assign in_exp  = W'(req_data.exponent_value);
   assign in_mod  = W'(req_data.modulus_value);

   // one reduced by the modulus
   assign unit_one = (mod_ff == W'(1)) ? '0 : W'(1);

   // one multiplier step: double the accumulator, then add a if the bit is set
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, mod_ff}) ? W'(dbl - {1'b0, mod_ff}) : dbl[W-1:0];
      sum     = {1'b0, dbl_red} + {1'b0, a_ff};
      if (b_ff[W-1]) begin
         step_acc = (sum >= {1'b0, mod_ff}) ? W'(sum - {1'b0, mod_ff}) : sum[W-1:0];
      end else begin
         step_acc = dbl_red;
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      mod_in    = mod_ff;
      exp_in    = exp_ff;
      base_in   = base_ff;
      result_in = result_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      rsp_in    = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mod_in = in_mod;
               exp_in = in_exp;
               if (in_mod == '0) begin
                  rsp_in.power_result       = '0;
                  rsp_in.zero_modulus_error = 1'b1;
                  state_in                  = S_DONE;
               end else if (in_exp == '0) begin
                  rsp_in.power_result       = FIELD_WIDTH'(1);
                  rsp_in.zero_modulus_error = 1'b0;
                  state_in                  = S_DONE;
               end else begin
                  // base mod m as the product of one and the base
                  a_in     = (in_mod == W'(1)) ? '0 : W'(1);
                  b_in     = in_base;
                  acc_in   = '0;
                  cnt_in   = CNT_WIDTH'(W - 1);
                  op_in    = OP_REDUCE;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            acc_in = step_acc;
            b_in   = {b_ff[W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_WIDTH'(1);
            if (cnt_ff == '0) begin
               unique case (op_ff)
                  OP_REDUCE: begin
                     base_in   = step_acc;
                     result_in = unit_one;
                     state_in  = S_NEXT;
                  end
                  OP_MULT: begin
                     // result updated, now square the base
                     result_in = step_acc;
                     a_in      = base_ff;
                     b_in      = base_ff;
                     acc_in    = '0;
                     cnt_in    = CNT_WIDTH'(W - 1);
                     op_in     = OP_SQUARE;
                  end
                  default: begin
                     base_in  = step_acc;
                     exp_in   = exp_ff >> 1;
                     state_in = S_NEXT;
                  end
               endcase
            end
         end
         S_NEXT: begin
            acc_in = '0;
            cnt_in = CNT_WIDTH'(W - 1);
            if (exp_ff == '0) begin
               rsp_in.power_result       = FIELD_WIDTH'(result_ff);
               rsp_in.zero_modulus_error = 1'b0;
               state_in                  = S_DONE;
            end else if (exp_ff[0]) begin
               a_in     = result_ff;
               b_in     = base_ff;
               op_in    = OP_MULT;
               state_in = S_MUL;
            end else begin
               a_in     = base_ff;
               b_in     = base_ff;
               op_in    = OP_SQUARE;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      mod_ff    <= mod_in;
      exp_ff    <= exp_in;
      base_ff   <= base_in;
      result_ff <= result_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      acc_ff    <= acc_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_data  = rsp_ff;

   // checks
   a_req_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");

   a_error_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_modulus_error) |-> (rsp_data.power_result == '0))
      else $error("zero modulus response carries a nonzero result");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (acc_ff < mod_ff && a_ff < mod_ff))
      else $error("multiplier operand not reduced by the modulus");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("unit not idle after reset");

endmodule

// ===== bench/modular_exponentiation_unit_test.sv =====
// self-checking testbench for modular_exponentiation_unit
// predicts each power with a double-width square and multiply and compares every response
// depends on mexp_pkg and the rtl of modular_exponentiation_unit
module modular_exponentiation_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mexp_pkg::*;

   // longest correct stretch without a transaction is one full exponentiation plus stalls
   localparam int QUIET_LIMIT = 10000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [FIELD_WIDTH-1:0] ALL_ONES = '1;

   typedef logic [OPERAND_WIDTH-1:0] operand_type;
   typedef logic [2*OPERAND_WIDTH-1:0] wide_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_payload_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_payload_type rsp_data;

   rsp_payload_type expected_powers[$];
   int mismatch_count = 0;
   int quiet_cycles = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;

   modular_exponentiation_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // (a * b) mod m, product kept at double width
   function automatic operand_type modular_product(operand_type a, operand_type b,
                                                   operand_type m);
      wide_type wa;
      wide_type wb;
      wide_type wm;
      wa = a;
      wb = b;
      wm = m;
      return operand_type'((wa * wb) % wm);
   endfunction

   // expected response for one request, right-to-left square and multiply
   function automatic rsp_payload_type predict_power(req_payload_type item);
      operand_type base;
      operand_type expo;
      operand_type modv;
      operand_type power;
      rsp_payload_type res;
      base = operand_type'(item.base_value);
      expo = operand_type'(item.exponent_value);
      modv = operand_type'(item.modulus_value);
      res = '0;
      if (modv == 0) begin
         res.zero_modulus_error = 1'b1;
         return res;
      end
      // zero exponent gives one, even for a modulus of one
      if (expo == 0) begin
         res.power_result = 1;
         return res;
      end
      base = base % modv;
      power = (modv == 1) ? operand_type'(0) : operand_type'(1);
      while (expo != 0) begin
         if (expo[0]) power = modular_product(power, base, modv);
         base = modular_product(base, base, modv);
         expo = expo >> 1;
      end
      res.power_result = FIELD_WIDTH'(power);
      return res;
   endfunction

   function automatic req_payload_type make_request(logic [FIELD_WIDTH-1:0] base,
                                                    logic [FIELD_WIDTH-1:0] expo,
                                                    logic [FIELD_WIDTH-1:0] modv);
      req_payload_type item;
      item.base_value = base;
      item.exponent_value = expo;
      item.modulus_value = modv;
      return item;
   endfunction

   // random request, weighted towards the corners and short exponents
   function automatic req_payload_type random_power_request();
      req_payload_type item;
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) item.modulus_value = '0;
      else if (pick < 10) item.modulus_value = 1;
      else if (pick < 25) item.modulus_value = $urandom_range(255, 2);
      else if (pick < 45) item.modulus_value = $urandom() | (1 << (FIELD_WIDTH - 1));
      else item.modulus_value = $urandom();
      pick = $urandom_range(99);
      if (pick < 5) item.exponent_value = '0;
      else if (pick < 35) item.exponent_value = $urandom_range(255, 1);
      else if (pick < 40) item.exponent_value = ALL_ONES;
      else item.exponent_value = $urandom();
      pick = $urandom_range(99);
      if (pick < 8) item.base_value = '0;
      else if (pick < 16) item.base_value = ALL_ONES;
      else if (pick < 24) item.base_value = item.modulus_value;
      else item.base_value = $urandom();
      return item;
   endfunction

   // present one request and hold it until the unit takes it
   task automatic send_power_request(input req_payload_type item);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_powers.push_back(predict_power(item));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_powers.size() != 0) @(posedge clock);
   endtask

   task automatic test_zero_modulus();
      send_power_request(make_request(5, 3, 0));
      send_power_request(make_request(ALL_ONES, ALL_ONES, 0));
      send_power_request(make_request(0, 0, 0));
      wait_for_results();
   endtask

   task automatic test_zero_exponent();
      send_power_request(make_request(7, 0, 13));
      send_power_request(make_request(ALL_ONES, 0, 1));
      send_power_request(make_request(0, 0, ALL_ONES));
      wait_for_results();
   endtask

   task automatic test_unit_modulus();
      send_power_request(make_request(ALL_ONES, ALL_ONES, 1));
      send_power_request(make_request(0, 5, 1));
      send_power_request(make_request(12345, 1, 1));
      wait_for_results();
   endtask

   // field extremes, large moduli where a single-width product would overflow
   task automatic test_operand_extremes();
      send_power_request(make_request(0, ALL_ONES, ALL_ONES));
      send_power_request(make_request(ALL_ONES, ALL_ONES, ALL_ONES));
      send_power_request(make_request(ALL_ONES, 1, 32'hFFFF_FFFE));
      send_power_request(make_request(2, ALL_ONES, 32'hFFFF_FFFB));
      send_power_request(make_request(32'hFFFF_FFFA, 2, 32'hFFFF_FFFB));
      send_power_request(make_request(46341, 2, ALL_ONES));
      send_power_request(make_request(3, 32'h8000_0000, 1000000007));
      send_power_request(make_request(ALL_ONES, ALL_ONES, 2));
      send_power_request(make_request(13, 5, 13));
      send_power_request(make_request(100, 3, 7));
      send_power_request(make_request(123456789, 1, 1000));
      send_power_request(make_request(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAB));
      wait_for_results();
   endtask

   task automatic test_random_powers(input int count, input int send_pct, input int recv_pct);
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      repeat (count) send_power_request(random_power_request());
      wait_for_results();
   endtask

   // response side back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_powers.size() == 0) begin
            $error("unexpected response transaction: power_result %0d", rsp_data.power_result);
            mismatch_count++;
         end else begin
            want = expected_powers.pop_front();
            if (rsp_data.power_result !== want.power_result) begin
               $error("power_result: expected %0d, actual %0d",
                      want.power_result, rsp_data.power_result);
               mismatch_count++;
            end
            if (rsp_data.zero_modulus_error !== want.zero_modulus_error) begin
               $error("zero_modulus_error: expected %0d, actual %0d",
                      want.zero_modulus_error, rsp_data.zero_modulus_error);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_modulus();
      test_zero_exponent();
      test_unit_modulus();
      test_operand_extremes();
      test_random_powers(83, 6, 84);
      test_random_powers(83, 84, 6);
      test_random_powers(83, 0, 0);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_powers.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/mexp_pkg.sv
rtl/core/modular_exponentiation_unit.sv
bench/modular_exponentiation_unit_test.sv
